// ===== hw/rtl/dwarf_line_program_lookup_defines.svh =====
// ----------------------------------------------------------------------------
// DWARF line program lookup assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DWARF_LINE_PROGRAM_LOOKUP_DEFINES_SVH
`define DWARF_LINE_PROGRAM_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DLPL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DLPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dlpl_pkg.sv =====
// ----------------------------------------------------------------------------
// DWARF line program lookup package
// Shared types, opcodes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dlpl_pkg;

  localparam int ADDRESS_WIDTH_DEF      = 32;
  localparam int OPCODE_TABLE_DEPTH_DEF = 256;

  localparam int DIV_W        = 65;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 200;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_OPCODE_BASE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BASE       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_RANGE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INSN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OPS         = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_IS_STMT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ADDRESS  = 3'd6;

  localparam logic [7:0] RST_OPCODE_BASE     = 8'd13;
  localparam logic [7:0] RST_LINE_BASE       = 8'hFB;
  localparam logic [7:0] RST_LINE_RANGE      = 8'd14;
  localparam logic [7:0] RST_MIN_INSN_LENGTH = 8'd1;
  localparam logic [7:0] RST_MAX_OPS         = 8'd1;
  localparam logic       RST_DEFAULT_IS_STMT = 1'b1;

  localparam logic [7:0] LNS_EXTENDED       = 8'd0;
  localparam logic [7:0] LNS_COPY           = 8'd1;
  localparam logic [7:0] LNS_ADVANCE_PC     = 8'd2;
  localparam logic [7:0] LNS_ADVANCE_LINE   = 8'd3;
  localparam logic [7:0] LNS_SET_FILE       = 8'd4;
  localparam logic [7:0] LNS_SET_COLUMN     = 8'd5;
  localparam logic [7:0] LNS_NEGATE_STMT    = 8'd6;
  localparam logic [7:0] LNS_SET_BB         = 8'd7;
  localparam logic [7:0] LNS_CONST_ADD_PC   = 8'd8;
  localparam logic [7:0] LNS_FIXED_ADV_PC   = 8'd9;
  localparam logic [7:0] LNS_PROLOGUE_END   = 8'd10;
  localparam logic [7:0] LNS_EPILOGUE_BEGIN = 8'd11;
  localparam logic [7:0] LNS_SET_ISA        = 8'd12;

  localparam logic [7:0] LNE_END_SEQUENCE   = 8'd1;
  localparam logic [7:0] LNE_SET_ADDRESS    = 8'd2;
  localparam logic [7:0] LNE_SET_DISCRIM    = 8'd4;

  localparam logic [7:0] CONST_ADD_OPCODE   = 8'd255;

  localparam int FLG_VALID  = 0;
  localparam int FLG_STMT   = 1;
  localparam int FLG_PROLOG = 2;
  localparam int FLG_BBLOCK = 3;
  localparam int FLG_EPILOG = 4;

  localparam int         LEB_CONT_BIT = 7;
  localparam int         LEB_SIGN_BIT = 6;
  localparam logic [6:0] LEB_LIMIT    = 7'd64;

  typedef enum logic [3:0] {
    PH_OPCODE,
    PH_ULEB,
    PH_SLEB,
    PH_EXT_LEN,
    PH_EXT_OP,
    PH_EXT_ADDR,
    PH_EXT_DISC,
    PH_EXT_SKIP,
    PH_FIXED_LO,
    PH_FIXED_HI,
    PH_CUSTOM
  } dlpl_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV1,
    ST_ADV,
    ST_DIV2,
    ST_TEST,
    ST_DONE
  } dlpl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div1;
    logic adv;
    logic div2;
    logic test;
    logic finish;
  } dlpl_cmd_t;

  typedef struct packed {
    logic go_div1;
    logic go_adv;
    logic go_test;
    logic div_done;
    logic maxops_one;
    logic row_pending;
    logic out_needed;
    logic out_free;
  } dlpl_stat_t;

endpackage

// ===== hw/rtl/dlpl_div.sv =====
// ----------------------------------------------------------------------------
// DWARF line program lookup divider
// Restoring divider by an 8-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlpl_div #(
  parameter int DVW = 65
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [7:0]     divisor,
  output logic [DVW-1:0] quotient,
  output logic [7:0]     remainder,
  output logic           done
);
  localparam int CNW = $clog2(DVW + 1);

  logic [DVW-1:0] quo_r;
  logic [7:0]     rem_r;
  logic [7:0]     dvs_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [8:0]     trial;
  logic [8:0]     diff;
  logic           ge;

  assign trial = {rem_r, quo_r[DVW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(DVW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[7:0] : trial[7:0];
      quo_r <= {quo_r[DVW-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

// ===== hw/rtl/dlpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// DWARF line program lookup controller
// Sequences one beat through decode, division, address advance and row test.
// ----------------------------------------------------------------------------
module dlpl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  dlpl_pkg::dlpl_stat_t   stat,
  output dlpl_pkg::dlpl_cmd_t    cmd
);
  import dlpl_pkg::*;

  dlpl_state_t state_r;
  dlpl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.go_div1)      state_nxt = ST_DIV1;
        else if (stat.go_adv)  state_nxt = ST_ADV;
        else if (stat.go_test) state_nxt = ST_TEST;
        else                   state_nxt = ST_DONE;
      end
      ST_DIV1: begin
        if (stat.div_done) state_nxt = ST_ADV;
      end
      ST_ADV: begin
        if (!stat.maxops_one)      state_nxt = ST_DIV2;
        else if (stat.row_pending) state_nxt = ST_TEST;
        else                       state_nxt = ST_DONE;
      end
      ST_DIV2: begin
        if (stat.div_done) state_nxt = stat.row_pending ? ST_TEST : ST_DONE;
      end
      ST_TEST: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_needed || stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_DIV1: cmd.div1 = 1'b1;
      ST_ADV:  cmd.adv  = 1'b1;
      ST_DIV2: cmd.div2 = 1'b1;
      ST_TEST: cmd.test = 1'b1;
      ST_DONE: cmd.finish = !stat.out_needed || stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/dlpl_dpath.sv =====
// ----------------------------------------------------------------------------
// DWARF line program lookup datapath
// Line state registers, opcode decoder, operand table and result register.
// ----------------------------------------------------------------------------
module dlpl_dpath #(
  parameter int ADDRESS_WIDTH      = dlpl_pkg::ADDRESS_WIDTH_DEF,
  parameter int OPCODE_TABLE_DEPTH = dlpl_pkg::OPCODE_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dlpl_pkg::dlpl_cmd_t               cmd,
  output dlpl_pkg::dlpl_stat_t              stat,
  input  logic [dlpl_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  logic                              cfg_valid,
  input  logic [dlpl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dlpl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dlpl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser
);
  import dlpl_pkg::*;

  localparam int AW  = ADDRESS_WIDTH;
  localparam int CW  = (AW > 32) ? AW : 32;
  localparam int TD  = OPCODE_TABLE_DEPTH;
  localparam int TIW = $clog2(TD);

  logic [7:0]  ob_r, lb_r, range_r, mil_r, maxops_r;
  logic        dis_r;
  logic [31:0] target_r;

  logic [7:0]  byte_r, tidx_r;
  logic        mode_r, last_r;
  logic [7:0]  tbl_q_r;
  logic        tbl_ok_r;
  logic [7:0]  tbl_mem [TD];
  logic [7:0]  rd_idx;

  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [7:0]    op_r, op_nxt;
  logic [31:0]   file_r, file_nxt, line_r, line_nxt, col_r, col_nxt, isa_r, isa_nxt;
  logic [4:0]    flags_r, flags_nxt;
  dlpl_phase_t   phase_r, phase_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [6:0]    sh_r, sh_nxt;
  logic [31:0]   bytes_r, bytes_nxt;
  logic          match_r, match_nxt, hit_r, hit_nxt;
  logic          special_r, special_nxt, rowp_r, rowp_nxt, endseq_r, endseq_nxt;
  logic [63:0]   adv_r, adv_nxt;
  logic          oval_r, oval_nxt, ouser_r, ouser_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;

  logic [6:0]    leb_sh;
  logic [63:0]   leb_acc, sleb_acc, addr_acc;
  logic          leb_done;
  logic [31:0]   bytes_dec, ext_len;
  logic [31:0]   lb_ext;
  logic [4:0]    flags_rst;
  logic          maxops_one, hit_cond, out_needed, tidx_ok;
  logic          go_div1, go_adv, go_test;
  logic [AW-1:0] mul_src, adv_mul;
  logic [7:0]    range_eff, div1_num;
  logic          div_start, div_done;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [7:0]    div_dvs, div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_r     <= RST_OPCODE_BASE;
      lb_r     <= RST_LINE_BASE;
      range_r  <= RST_LINE_RANGE;
      mil_r    <= RST_MIN_INSN_LENGTH;
      maxops_r <= RST_MAX_OPS;
      dis_r    <= RST_DEFAULT_IS_STMT;
      target_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OPCODE_BASE:     ob_r     <= cfg_data[7:0];
        CFG_LINE_BASE:       lb_r     <= cfg_data[7:0];
        CFG_LINE_RANGE:      range_r  <= cfg_data[7:0];
        CFG_MIN_INSN_LENGTH: mil_r    <= cfg_data[7:0];
        CFG_MAX_OPS:         maxops_r <= cfg_data[7:0];
        CFG_DEFAULT_IS_STMT: dis_r    <= cfg_data[0];
        CFG_TARGET_ADDRESS:  target_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rd_idx  = in_tdata[7:0] - 8'd1;
  assign tidx_ok = {1'b0, tidx_r} < 9'(TD);

  always_ff @(posedge clk) begin
    if (cmd.exec && mode_r && tidx_ok) begin
      tbl_mem[tidx_r[TIW-1:0]] <= byte_r;
    end
    if (cmd.load) begin
      tbl_q_r  <= tbl_mem[rd_idx[TIW-1:0]];
      tbl_ok_r <= {1'b0, rd_idx} < 9'(TD);
      byte_r   <= in_tdata[7:0];
      tidx_r   <= in_tdata[15:8];
      mode_r   <= in_tuser;
      last_r   <= in_tlast;
    end
  end

  assign maxops_one = maxops_r <= 8'd1;
  assign range_eff  = (range_r == 8'd0) ? 8'd1 : range_r;
  assign lb_ext     = {{24{lb_r[7]}}, lb_r};
  assign flags_rst  = 5'((1 << FLG_VALID) | (1 << FLG_PROLOG)) |
                      (dis_r ? 5'(1 << FLG_STMT) : 5'd0);

  assign leb_sh   = sh_r + 7'd7;
  assign leb_acc  = (sh_r < LEB_LIMIT) ? (acc_r | (64'(byte_r[6:0]) << sh_r[5:0])) : acc_r;
  assign leb_done = !byte_r[LEB_CONT_BIT] || (leb_sh >= LEB_LIMIT);
  assign sleb_acc = ((leb_sh < LEB_LIMIT) && byte_r[LEB_SIGN_BIT]) ?
                    (leb_acc | ({64{1'b1}} << leb_sh[5:0])) : leb_acc;
  assign addr_acc = (sh_r < LEB_LIMIT) ? (acc_r | (64'(byte_r) << sh_r[5:0])) : acc_r;
  assign bytes_dec = bytes_r - 32'd1;
  assign ext_len   = (|leb_acc[63:32]) ? {32{1'b1}} : leb_acc[31:0];

  assign hit_cond = (CW'(prev_r) <= CW'(target_r)) && (CW'(addr_r) >= CW'(target_r));
  assign out_needed = !mode_r && (hit_r || (last_r && !match_r));

  assign mul_src = cmd.div2 ? div_q[AW-1:0] : adv_r[AW-1:0];
  assign adv_mul = mul_src * AW'(mil_r);

  assign div1_num  = (byte_r >= ob_r) ? (byte_r - ob_r) : (CONST_ADD_OPCODE - ob_r);
  assign div_start = (cmd.exec && go_div1) || (cmd.adv && !maxops_one);
  assign div_dvd   = cmd.exec ? DIV_W'(div1_num) : (DIV_W'(op_r) + DIV_W'(adv_r));
  assign div_dvs   = cmd.exec ? range_eff : maxops_r;

  dlpl_div #(
    .DVW (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  always_comb begin
    addr_nxt    = addr_r;
    prev_nxt    = prev_r;
    op_nxt      = op_r;
    file_nxt    = file_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    isa_nxt     = isa_r;
    flags_nxt   = flags_r;
    phase_nxt   = phase_r;
    pend_nxt    = pend_r;
    acc_nxt     = acc_r;
    sh_nxt      = sh_r;
    bytes_nxt   = bytes_r;
    match_nxt   = match_r;
    hit_nxt     = hit_r;
    special_nxt = special_r;
    rowp_nxt    = rowp_r;
    endseq_nxt  = endseq_r;
    adv_nxt     = adv_r;
    oval_nxt    = oval_r;
    ouser_nxt   = ouser_r;
    odata_nxt   = odata_r;
    go_div1     = 1'b0;
    go_adv      = 1'b0;
    go_test     = 1'b0;

    if (oval_r && out_tready) oval_nxt = 1'b0;

    if (cmd.exec && !mode_r && !match_r) begin
      special_nxt = 1'b0;
      rowp_nxt    = 1'b0;
      endseq_nxt  = 1'b0;
      case (phase_r)
        PH_OPCODE: begin
          if (byte_r >= ob_r) begin
            special_nxt = 1'b1;
            rowp_nxt    = 1'b1;
            go_div1     = 1'b1;
          end else begin
            case (byte_r)
              LNS_EXTENDED: begin
                acc_nxt   = '0;
                sh_nxt    = '0;
                phase_nxt = PH_EXT_LEN;
              end
              LNS_COPY: begin
                rowp_nxt = 1'b1;
                go_test  = 1'b1;
              end
              LNS_ADVANCE_PC, LNS_SET_FILE, LNS_SET_COLUMN, LNS_SET_ISA: begin
                pend_nxt  = byte_r;
                acc_nxt   = '0;
                sh_nxt    = '0;
                phase_nxt = PH_ULEB;
              end
              LNS_ADVANCE_LINE: begin
                pend_nxt  = byte_r;
                acc_nxt   = '0;
                sh_nxt    = '0;
                phase_nxt = PH_SLEB;
              end
              LNS_NEGATE_STMT:    flags_nxt[FLG_STMT]   = !flags_r[FLG_STMT];
              LNS_SET_BB:         flags_nxt[FLG_BBLOCK] = 1'b1;
              LNS_CONST_ADD_PC:   go_div1 = 1'b1;
              LNS_FIXED_ADV_PC:   phase_nxt = PH_FIXED_LO;
              LNS_PROLOGUE_END:   flags_nxt[FLG_PROLOG] = 1'b0;
              LNS_EPILOGUE_BEGIN: flags_nxt[FLG_EPILOG] = 1'b1;
              default: begin
                if (tbl_ok_r && (tbl_q_r != 8'd0)) begin
                  bytes_nxt = 32'(tbl_q_r);
                  acc_nxt   = '0;
                  sh_nxt    = '0;
                  phase_nxt = PH_CUSTOM;
                end
              end
            endcase
          end
        end
        PH_ULEB: begin
          acc_nxt = leb_acc;
          sh_nxt  = leb_sh;
          if (leb_done) begin
            phase_nxt = PH_OPCODE;
            case (pend_r)
              LNS_ADVANCE_PC: begin
                adv_nxt = leb_acc;
                go_adv  = 1'b1;
              end
              LNS_SET_FILE:   file_nxt = leb_acc[31:0];
              LNS_SET_COLUMN: col_nxt  = leb_acc[31:0];
              default:        isa_nxt  = leb_acc[31:0];
            endcase
          end
        end
        PH_SLEB: begin
          acc_nxt = leb_acc;
          sh_nxt  = leb_sh;
          if (leb_done) begin
            acc_nxt   = sleb_acc;
            line_nxt  = line_r + sleb_acc[31:0];
            phase_nxt = PH_OPCODE;
          end
        end
        PH_EXT_LEN: begin
          acc_nxt = leb_acc;
          sh_nxt  = leb_sh;
          if (leb_done) begin
            bytes_nxt = ext_len;
            phase_nxt = (ext_len != 32'd0) ? PH_EXT_OP : PH_OPCODE;
          end
        end
        PH_EXT_OP: begin
          bytes_nxt = bytes_dec;
          pend_nxt  = byte_r;
          acc_nxt   = '0;
          sh_nxt    = '0;
          case (byte_r)
            LNE_END_SEQUENCE: begin
              rowp_nxt   = 1'b1;
              endseq_nxt = 1'b1;
              go_test    = 1'b1;
              phase_nxt  = (bytes_dec != 32'd0) ? PH_EXT_SKIP : PH_OPCODE;
            end
            LNE_SET_ADDRESS: begin
              if (bytes_dec != 32'd0) begin
                phase_nxt = PH_EXT_ADDR;
              end else begin
                addr_nxt  = '0;
                op_nxt    = '0;
                phase_nxt = PH_OPCODE;
              end
            end
            LNE_SET_DISCRIM: begin
              phase_nxt = (bytes_dec != 32'd0) ? PH_EXT_DISC : PH_OPCODE;
            end
            default: begin
              phase_nxt = (bytes_dec != 32'd0) ? PH_EXT_SKIP : PH_OPCODE;
            end
          endcase
        end
        PH_EXT_ADDR: begin
          acc_nxt   = addr_acc;
          sh_nxt    = (sh_r < LEB_LIMIT) ? (sh_r + 7'd8) : sh_r;
          bytes_nxt = bytes_dec;
          if (bytes_dec == 32'd0) begin
            addr_nxt  = addr_acc[AW-1:0];
            op_nxt    = '0;
            phase_nxt = PH_OPCODE;
          end
        end
        PH_EXT_DISC: begin
          acc_nxt   = leb_acc;
          sh_nxt    = leb_sh;
          bytes_nxt = bytes_dec;
          if (leb_done || (bytes_dec == 32'd0)) begin
            phase_nxt = (bytes_dec != 32'd0) ? PH_EXT_SKIP : PH_OPCODE;
          end
        end
        PH_EXT_SKIP: begin
          bytes_nxt = bytes_dec;
          if (bytes_dec == 32'd0) phase_nxt = PH_OPCODE;
        end
        PH_FIXED_LO: begin
          acc_nxt   = 64'(byte_r);
          phase_nxt = PH_FIXED_HI;
        end
        PH_FIXED_HI: begin
          addr_nxt  = addr_r + AW'({byte_r, acc_r[7:0]});
          op_nxt    = '0;
          phase_nxt = PH_OPCODE;
        end
        PH_CUSTOM: begin
          if (leb_done) begin
            acc_nxt   = '0;
            sh_nxt    = '0;
            bytes_nxt = bytes_dec;
            if (bytes_dec == 32'd0) phase_nxt = PH_OPCODE;
          end else begin
            acc_nxt = leb_acc;
            sh_nxt  = leb_sh;
          end
        end
        default: phase_nxt = PH_OPCODE;
      endcase
    end

    if (cmd.div1 && div_done) begin
      adv_nxt = div_q[63:0];
      if (special_r) line_nxt = line_r + 32'(div_r) + lb_ext;
    end

    if (cmd.adv && maxops_one) addr_nxt = addr_r + adv_mul;

    if (cmd.div2 && div_done) begin
      addr_nxt = addr_r + adv_mul;
      op_nxt   = div_r;
    end

    if (cmd.test) begin
      if (hit_cond) begin
        hit_nxt   = 1'b1;
        match_nxt = 1'b1;
      end else begin
        prev_nxt = addr_r;
        if (endseq_r) begin
          addr_nxt  = '0;
          op_nxt    = '0;
          file_nxt  = 32'd1;
          line_nxt  = 32'd1;
          col_nxt   = '0;
          isa_nxt   = '0;
          flags_nxt = flags_rst;
        end else begin
          flags_nxt[FLG_BBLOCK] = 1'b0;
          flags_nxt[FLG_EPILOG] = 1'b0;
          flags_nxt[FLG_PROLOG] = 1'b1;
        end
      end
    end

    if (cmd.finish) begin
      if (out_needed) begin
        oval_nxt  = 1'b1;
        ouser_nxt = hit_r;
        odata_nxt = hit_r ? OUT_TDATA_W'({flags_r, isa_r, file_r, col_r, line_r,
                                          32'(addr_r), 32'(prev_r)}) : '0;
      end
      hit_nxt = 1'b0;
      if (!mode_r && last_r) begin
        addr_nxt  = '0;
        op_nxt    = '0;
        file_nxt  = 32'd1;
        line_nxt  = 32'd1;
        col_nxt   = '0;
        isa_nxt   = '0;
        flags_nxt = flags_rst;
        prev_nxt  = '1;
        phase_nxt = PH_OPCODE;
        pend_nxt  = '0;
        acc_nxt   = '0;
        sh_nxt    = '0;
        bytes_nxt = '0;
        match_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      prev_r    <= '1;
      op_r      <= '0;
      file_r    <= 32'd1;
      line_r    <= 32'd1;
      col_r     <= '0;
      isa_r     <= '0;
      flags_r   <= 5'((1 << FLG_VALID) | (1 << FLG_PROLOG)) |
                   (RST_DEFAULT_IS_STMT ? 5'(1 << FLG_STMT) : 5'd0);
      phase_r   <= PH_OPCODE;
      pend_r    <= '0;
      acc_r     <= '0;
      sh_r      <= '0;
      bytes_r   <= '0;
      match_r   <= 1'b0;
      hit_r     <= 1'b0;
      special_r <= 1'b0;
      rowp_r    <= 1'b0;
      endseq_r  <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      addr_r    <= addr_nxt;
      prev_r    <= prev_nxt;
      op_r      <= op_nxt;
      file_r    <= file_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      isa_r     <= isa_nxt;
      flags_r   <= flags_nxt;
      phase_r   <= phase_nxt;
      pend_r    <= pend_nxt;
      acc_r     <= acc_nxt;
      sh_r      <= sh_nxt;
      bytes_r   <= bytes_nxt;
      match_r   <= match_nxt;
      hit_r     <= hit_nxt;
      special_r <= special_nxt;
      rowp_r    <= rowp_nxt;
      endseq_r  <= endseq_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adv_r   <= adv_nxt;
    ouser_r <= ouser_nxt;
    odata_r <= odata_nxt;
  end

  assign stat.go_div1     = go_div1;
  assign stat.go_adv      = go_adv;
  assign stat.go_test     = go_test;
  assign stat.div_done    = div_done;
  assign stat.maxops_one  = maxops_one;
  assign stat.row_pending = rowp_r;
  assign stat.out_needed  = out_needed;
  assign stat.out_free    = !oval_r || out_tready;

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

// ===== hw/rtl/dwarf_line_program_lookup.sv =====
// ----------------------------------------------------------------------------
// DWARF line program lookup
// Interprets a line-number program byte by byte and reports the row whose
// address range brackets the target address.
// ----------------------------------------------------------------------------
// The block takes one beat at a time and accepts the next beat once the
// previous one is fully processed. A special opcode or a constant address
// advance runs the shared 65-step restoring divider once for the line range
// and, when more than one operation per instruction is configured, once
// more for the op index; an advance_pc operand also uses the divider in that
// case. A finished result waits in the output register while the next beat
// is accepted.
module dwarf_line_program_lookup #(
  parameter int ADDRESS_WIDTH      = dlpl_pkg::ADDRESS_WIDTH_DEF,
  parameter int OPCODE_TABLE_DEPTH = dlpl_pkg::OPCODE_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // byte_value [7:0], table_index [15:8]
  input  logic [dlpl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode [0]
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // address_before [31:0], address_after [63:32], line [95:64],
  // column [127:96], file_number [159:128], isa [191:160],
  // row_flags [196:192], zero [199:197]
  output logic [dlpl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // found [0]
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dlpl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dlpl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dlpl_pkg::*;

  dlpl_cmd_t  cmd;
  dlpl_stat_t stat;

  assign cfg_ready = 1'b1;

  dlpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dlpl_dpath #(
    .ADDRESS_WIDTH      (ADDRESS_WIDTH),
    .OPCODE_TABLE_DEPTH (OPCODE_TABLE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/dlpl_checker.sv =====
// ----------------------------------------------------------------------------
// DWARF line program lookup checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "dwarf_line_program_lookup_defines.svh"

module dlpl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dlpl_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser
);
  import dlpl_pkg::*;

  // A stalled result beat keeps its payload.
  `DLPL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result beat changed")

  // A miss carries an all-zero payload.
  `DLPL_ASSERT_SAME(a_miss_zero, out_tvalid && !out_tuser, out_tdata == '0, "miss beat with nonzero payload")

  // Every hit row has its valid flag set.
  `DLPL_ASSERT_SAME(a_hit_valid, out_tvalid && out_tuser, out_tdata[192 + FLG_VALID], "hit row without valid flag")

  // One beat is processed at a time.
  `DLPL_ASSERT_NEXT(a_one_beat, in_tvalid && in_tready, !in_tready, "input accepted while busy")

endmodule

bind dwarf_line_program_lookup dlpl_checker u_chk (.*);
